// File: hdl/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, masked during reset
`define SPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// Next-cycle implication, masked during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by the cell, the top level and the checker.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: hdl/sorted_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// Channels: input items (action_i, value_i) under in_valid_i/in_stall_o,
// result items (status_o, smallest_o, largest_o, count_o) under
// out_valid_o/out_stall_i. An item is taken at a clock edge with valid high
// and stall low.
// Every item gets exactly one result. The chain updates at the accepting
// edge; the result register samples the new front, tail and count as the
// middle stage advances. Throughput is one item per cycle when not stalled;
// each cell compares against the broadcast key and shifts in the same cycle.
// A stalled result holds in its output register while the next item's status
// waits in the middle stage; with both full, in_stall_o rises and the chain
// stays still.
// Reset empties the queue (count zero, both stages empty); the stored keys
// are left as they are and are never shown while the count excludes them.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic signed [KEY_W-1:0]   value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [KEY_W-1:0]   smallest_o,
  output logic signed [KEY_W-1:0]   largest_o,
  output logic [COUNT_W-1:0]        count_o
);

  logic signed [KEY_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]     lt_w, match_w, occ_w;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    a_valid_q, out_valid_q;
  status_e                 a_status_q, a_status_d;
  status_e                 out_status_q;
  logic signed [KEY_W-1:0] smallest_q, largest_q, largest_w;
  logic [CNT_W-1:0]        out_count_q;
  logic                    adv, accept, found, full, empty;
  cell_ctrl_t              ctrl;

  // Handshake: the result stage frees up when empty or taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign found = |match_w;
  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Broadcast the operation to the chain
  always_comb begin
    ctrl.key = value_i;
    ctrl.ins = accept && (action_e'(action_i) == ACT_INSERT) && !full;
    ctrl.rem = accept && (action_e'(action_i) == ACT_REMOVE) && found;
  end

  // Status of the accepted item
  always_comb begin
    a_status_d = ST_DONE;
    if (action_e'(action_i) == ACT_INSERT) begin
      if (full) a_status_d = ST_FULL;
    end else if (empty) begin
      a_status_d = ST_EMPTY;
    end else if (!found) begin
      a_status_d = ST_NOT_FOUND;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) count_d = count_q + CNT_W'(1);
    else if (ctrl.rem) count_d = count_q - CNT_W'(1);
  end

  // Build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    lt_left;
    logic signed [KEY_W-1:0] left_entry, right_entry;

    assign occ_w[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign lt_left    = 1'b1;
      assign left_entry = value_i;
    end else begin : g_inner
      assign lt_left    = lt_w[i-1];
      assign left_entry = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_mid
      assign right_entry = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ_w[i]),
      .lt_left_i     (lt_left),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .lt_o          (lt_w[i]),
      .match_o       (match_w[i])
    );
  end

  // Select the tail cell: occupied, and last or with an unoccupied right neighbor
  always_comb begin
    largest_w = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (occ_w[i] && (i == CAPACITY - 1 || !occ_w[(i + 1) % CAPACITY])) begin
        largest_w = largest_w | entry_w[i];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) a_valid_q <= 1'b1;
      else if (adv) a_valid_q <= 1'b0;
      if (adv) out_valid_q <= a_valid_q;
    end
  end

  // Payload registers: hold status, then sample the updated chain
  always_ff @(posedge clk_i) begin
    if (accept) a_status_q <= a_status_d;
    if (adv && a_valid_q) begin
      out_status_q <= a_status_q;
      smallest_q   <= occ_w[0] ? entry_w[0] : '0;
      largest_q    <= largest_w;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign smallest_o  = smallest_q;
  assign largest_o   = largest_q;
  assign count_o     = COUNT_W'(out_count_q);

endmodule

// File: hdl/spq_cell.sv
// One storage cell of the sorted chain: holds one key and shifts it.
// Depends on spq_pkg for the key width and the broadcast control struct.
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic                    occ_i,
  input  logic                    lt_left_i,
  input  logic signed [KEY_W-1:0] left_entry_i,
  input  logic signed [KEY_W-1:0] right_entry_i,
  output logic signed [KEY_W-1:0] entry_o,
  output logic                    lt_o,
  output logic                    match_o
);

  logic signed [KEY_W-1:0] entry_q, entry_d;

  // Compare the stored key against the broadcast key
  assign lt_o    = occ_i && (entry_q < ctrl_i.key);
  assign match_o = occ_i && (entry_q == ctrl_i.key);
  assign entry_o = entry_q;

  // Insert: the first cell not below the key takes it, later cells shift right.
  // Remove: every cell not below the key pulls from its right neighbor.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !lt_o) begin
      entry_d = lt_left_i ? ctrl_i.key : left_entry_i;
    end else if (ctrl_i.rem && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: hdl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [STATUS_W-1:0]     status_o,
  input logic signed [KEY_W-1:0] smallest_o,
  input logic signed [KEY_W-1:0] largest_o,
  input logic [COUNT_W-1:0]      count_o
);

  // Empty queue reports zero front and tail
  `SPQ_ASSERT_IMPL(a_empty_zero, out_valid_o && count_o == '0,
                   smallest_o == '0 && largest_o == '0)

  // Front never above tail
  `SPQ_ASSERT_IMPL(a_order, out_valid_o && count_o != '0, smallest_o <= largest_o)

  // A dropped insert only happens at capacity
  `SPQ_ASSERT_IMPL(a_full_count, out_valid_o && status_o == ST_FULL,
                   count_o == COUNT_W'(CAPACITY))

  // A stalled result holds
  `SPQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(status_o) && $stable(smallest_o) &&
                   $stable(largest_o) && $stable(count_o))

  // Input stalls only while a result waits on a stalled receiver
  `SPQ_ASSERT_IMPL(a_in_stall, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
